// ----- hdl/dfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_pkg
// Types and constants shared by the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int unsigned FRAME_LEN = 7;
  localparam int unsigned CNT_W     = 3;

  typedef logic [7:0]       byte_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam byte_t START_BYTE = 8'h11;
  localparam byte_t END_BYTE   = 8'h12;

  typedef struct packed {
    byte_t frame_type;
    byte_t payload_0;
    byte_t payload_1;
    byte_t payload_2;
    byte_t payload_3;
  } result_t;

  // handshake between the input register and the frame engine
  typedef struct packed {
    logic  valid;
    byte_t rx_byte;
  } in_beat_t;

endpackage

// ----- hdl/dfr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_if
// Valid/ready channels for received bytes and for decoded frames.
// ----------------------------------------------------------------------------
interface dfr_in_if;
  logic          valid;
  logic          ready;
  dfr_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
  logic          valid;
  logic          ready;
  dfr_pkg::byte_t frame_type;
  dfr_pkg::byte_t payload_0;
  dfr_pkg::byte_t payload_1;
  dfr_pkg::byte_t payload_2;
  dfr_pkg::byte_t payload_3;

  modport source (output valid, output frame_type, output payload_0, output payload_1,
                  output payload_2, output payload_3, input ready);
  modport sink   (input valid, input frame_type, input payload_0, input payload_1,
                  input payload_2, input payload_3, output ready);
endinterface

// ----- hdl/dfr_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_in_stage
// Input register: holds one received byte until the frame engine takes it.
// ----------------------------------------------------------------------------
module dfr_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dfr_pkg::byte_t    in_rx_byte,
  input  logic              take,
  output dfr_pkg::in_beat_t beat
);

  logic           vld_r;
  logic           vld_nxt;
  dfr_pkg::byte_t byte_r;

  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign beat.valid   = vld_r;
  assign beat.rx_byte = byte_r;

endmodule

// ----- hdl/dfr_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_engine
// Frame store, delimiter check and resync shift; one byte per cycle on fire.
// ----------------------------------------------------------------------------
module dfr_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  dfr_pkg::in_beat_t beat,
  input  logic              fire,
  output logic              res_valid,
  output dfr_pkg::result_t  res
);

  localparam int unsigned N = dfr_pkg::FRAME_LEN;

  dfr_pkg::byte_t store_r   [N];
  dfr_pkg::byte_t store_nxt [N];
  dfr_pkg::byte_t ext       [N];
  dfr_pkg::cnt_t  cnt_r;
  dfr_pkg::cnt_t  cnt_nxt;
  dfr_pkg::cnt_t  cnt_eff;
  dfr_pkg::cnt_t  shift;
  logic           full;
  logic           match;
  logic           found;

  always_comb begin
    // a count of seven never occurs, but it reads as empty
    cnt_eff = (cnt_r >= dfr_pkg::CNT_W'(N)) ? '0 : cnt_r;
    for (int j = 0; j < N; j++) begin
      ext[j] = (cnt_eff == dfr_pkg::CNT_W'(j)) ? beat.rx_byte : store_r[j];
    end
    full  = (cnt_eff == dfr_pkg::CNT_W'(N - 1));
    match = (ext[0] == dfr_pkg::START_BYTE) && (ext[N-1] == dfr_pkg::END_BYTE);

    // first later start byte, lowest position wins
    found = 1'b0;
    shift = '0;
    for (int i = N - 1; i >= 1; i--) begin
      if (ext[i] == dfr_pkg::START_BYTE) begin
        found = 1'b1;
        shift = dfr_pkg::CNT_W'(i);
      end
    end

    store_nxt = ext;
    cnt_nxt   = cnt_eff + dfr_pkg::CNT_W'(1);
    res_valid = 1'b0;
    res.frame_type = ext[1];
    res.payload_0  = ext[2];
    res.payload_1  = ext[3];
    res.payload_2  = ext[4];
    res.payload_3  = ext[5];

    if (full) begin
      if (match) begin
        res_valid = 1'b1;
        cnt_nxt   = '0;
      end else if (found) begin
        for (int j = 0; j < N; j++) begin
          for (int i = 1; j + i < N; i++) begin
            if (shift == dfr_pkg::CNT_W'(i)) begin
              store_nxt[j] = ext[j+i];
            end
          end
        end
        cnt_nxt = dfr_pkg::CNT_W'(N) - shift;
      end else begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      store_r <= store_nxt;
    end
  end

endmodule

// ----- hdl/dfr_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_out_stage
// Result register: holds a decoded frame until the sink takes it.
// ----------------------------------------------------------------------------
module dfr_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             res_valid,
  input  dfr_pkg::result_t res,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output dfr_pkg::result_t out_data
);

  logic             vld_r;
  logic             vld_nxt;
  dfr_pkg::result_t data_r;

  assign slot_free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (fire) begin
      vld_nxt = res_valid;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// ----- hdl/delimited_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_receiver
// Finds seven-byte frames (0x11, type, four payload bytes, 0x12) in a byte
// stream and delivers type and payload of each valid frame.
//
// in_ch carries one received byte per beat; out_ch carries one decoded frame
// per beat. Bytes that do not complete a valid frame give no output beat.
// A byte is registered in the input register on acceptance, processed by
// the engine when it fires, and its frame is registered in the result
// register and offered on out_ch from there.
// One byte is taken every cycle while out_ch drains; the single loop that
// sets this is the frame store update, which is combinational.
// After a full store without delimiters, the store shifts so that the
// first later 0x11 leads, or empties if there is none.
// Reset empties the store and both registers. When the sink holds
// out_ready low with a frame waiting, the engine stops and in_ch takes at
// most one more byte into its input register.
// ----------------------------------------------------------------------------
module delimited_frame_receiver (
  input  logic      clk,
  input  logic      rst_n,
  dfr_in_if.sink    in_ch,
  dfr_out_if.source out_ch
);

  dfr_pkg::in_beat_t beat;
  dfr_pkg::result_t  res;
  dfr_pkg::result_t  out_data;
  logic              res_valid;
  logic              slot_free;
  logic              fire;

  assign fire = beat.valid && slot_free;

  dfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_rx_byte (in_ch.rx_byte),
    .take       (fire),
    .beat       (beat)
  );

  dfr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res)
  );

  dfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.frame_type = out_data.frame_type;
  assign out_ch.payload_0  = out_data.payload_0;
  assign out_ch.payload_1  = out_data.payload_1;
  assign out_ch.payload_2  = out_data.payload_2;
  assign out_ch.payload_3  = out_data.payload_3;

endmodule
